// ===== rtl/tfe_pkg.sv =====
// Package for the time format expander: payload structs, job descriptor,
// character and register-index constants, digit helpers.
// No dependencies.
package tfe_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  // Cycles the digit pipeline needs after a register changes
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  localparam logic [2:0] CFG_YEAR   = 3'd0;
  localparam logic [2:0] CFG_MONTH  = 3'd1;
  localparam logic [2:0] CFG_DAY    = 3'd2;
  localparam logic [2:0] CFG_HOUR   = 3'd3;
  localparam logic [2:0] CFG_MINUTE = 3'd4;
  localparam logic [2:0] CFG_SECOND = 3'd5;
  localparam logic [2:0] CFG_LIMIT  = 3'd6;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_YEAR4   = 8'h59;
  localparam logic [7:0] CH_YEAR2   = 8'h79;
  localparam logic [7:0] CH_MONTH   = 8'h6D;
  localparam logic [7:0] CH_DAY     = 8'h64;
  localparam logic [7:0] CH_HOUR    = 8'h48;
  localparam logic [7:0] CH_MINUTE  = 8'h4D;
  localparam logic [7:0] CH_SECOND  = 8'h53;

  typedef struct packed {
    logic [7:0] format_char;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        last_of_run;
    logic        finished;
    logic        overflow;
    logic [15:0] total_length;
  } out_item_t;

  // Tens digit in [7:4], ones digit in [3:0]
  typedef logic [7:0] bcd2_t;

  typedef struct packed {
    bcd2_t       year_hi;
    bcd2_t       year_lo;
    bcd2_t       month;
    bcd2_t       day;
    bcd2_t       hour;
    bcd2_t       minute;
    bcd2_t       second;
    logic [15:0] limit;
    logic        busy;
  } cfg_view_t;

  // One run of output characters; chars[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      count;
    logic            fin;
    logic            ovf;
    logic [15:0]     len;
  } job_t;

  // Value below 100 to two BCD digits
  function automatic bcd2_t to_bcd2(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(10 * i)) tens = 4'(i);
    end
    ones = v - {3'b000, tens} * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CH_ZERO + {4'b0000, d};
  endfunction

endpackage

// ===== rtl/time_format_expander.sv =====
// Top level of the time format expander: configuration, front end, job
// queue and back end. Depends on tfe_pkg, tfe_cfg, tfe_front, tfe_queue, tfe_back.
//
// Format characters are pushed one per transaction and expanded into output
// characters, one result per cycle while pop keeps up. The front end takes a new
// item every cycle while the job queue has room and the digits are not settling;
// a plain character yields one output character, a two-digit directive or unknown
// directive two, %Y four, and the end item one or two (trailing percent). Sustained
// rate is therefore set by the back end's one-character-per-cycle output register,
// and a lone percent or a dropped item yields no output character. After reset
// and after every configuration write, full stays high while the decimal
// conversion pipeline settles.
module time_format_expander
  import tfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_view_t view;
  job_t      job, head;
  logic      job_valid, q_full, q_empty, q_pop, accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full || view.busy;
  assign accept    = push && !full;

  tfe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  tfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .view      (view),
    .job_valid (job_valid),
    .job       (job)
  );

  tfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_valid),
    .wr_data (job),
    .full    (q_full),
    .rd_en   (q_pop),
    .head    (head),
    .empty   (q_empty)
  );

  tfe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> full)
    else $error("item window open while digits settle");
  a_fin_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.finished |-> result.last_of_run)
    else $error("final result not last of its run");
  a_ovf_no_len: assert property (@(posedge clk) disable iff (rst)
    !empty && result.overflow |-> result.finished && result.total_length == 16'd0)
    else $error("overflow result carries a length");

endmodule

// ===== rtl/tfe_cfg.sv =====
// Configuration registers and the pipelined decimal conversion of the
// date/time values. Depends on tfe_pkg.
module tfe_cfg
  import tfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_view_t   view
);

  logic [12:0] year;
  logic [6:0]  month, day, hour, minute, second;
  logic [15:0] limit;
  logic [2:0]  busy;

  logic [13:0] year_mod1, year_mod2;
  logic [6:0]  month1, day1, hour1, minute1, second1;
  logic [6:0]  year_hi2, year_hi3, year_lo3;
  bcd2_t       year_hi4, year_lo4, month4, day4, hour4, minute4, second4;

  logic [13:0] year_sum;
  logic [26:0] year_prod;
  logic [13:0] year_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      year   <= '0;
      month  <= '0;
      day    <= '0;
      hour   <= '0;
      minute <= '0;
      second <= '0;
      limit  <= '0;
      busy   <= SETTLE_CYCLES;
    end else if (cfg_valid) begin
      busy <= SETTLE_CYCLES;
      case (cfg_index)
        CFG_YEAR:   year   <= cfg_data[12:0];
        CFG_MONTH:  month  <= cfg_data[6:0];
        CFG_DAY:    day    <= cfg_data[6:0];
        CFG_HOUR:   hour   <= cfg_data[6:0];
        CFG_MINUTE: minute <= cfg_data[6:0];
        CFG_SECOND: second <= cfg_data[6:0];
        CFG_LIMIT:  limit  <= cfg_data;
        default: ;
      endcase
    end else if (busy != 3'd0) begin
      busy <= busy - 3'd1;
    end
  end

  // x / 100 is exact as (x * 5243) >> 19 for x below 43699
  assign year_sum  = {1'b0, year} + 14'd1900;
  assign year_prod = 27'(year_mod1) * 27'd5243;
  assign year_rem  = year_mod2 - {7'b0, year_hi2} * 14'd100;

  // Free-running conversion; busy covers its latency after any write
  always_ff @(posedge clk) begin
    year_mod1 <= (year_sum >= 14'd10000) ? year_sum - 14'd10000 : year_sum;
    month1    <= (month  >= 7'd100) ? month  - 7'd100 : month;
    day1      <= (day    >= 7'd100) ? day    - 7'd100 : day;
    hour1     <= (hour   >= 7'd100) ? hour   - 7'd100 : hour;
    minute1   <= (minute >= 7'd100) ? minute - 7'd100 : minute;
    second1   <= (second >= 7'd100) ? second - 7'd100 : second;

    year_mod2 <= year_mod1;
    year_hi2  <= year_prod[25:19];

    year_hi3  <= year_hi2;
    year_lo3  <= year_rem[6:0];

    year_hi4  <= to_bcd2(year_hi3);
    year_lo4  <= to_bcd2(year_lo3);
    month4    <= to_bcd2(month1);
    day4      <= to_bcd2(day1);
    hour4     <= to_bcd2(hour1);
    minute4   <= to_bcd2(minute1);
    second4   <= to_bcd2(second1);
  end

  always_comb begin
    view.year_hi = year_hi4;
    view.year_lo = year_lo4;
    view.month   = month4;
    view.day     = day4;
    view.hour    = hour4;
    view.minute  = minute4;
    view.second  = second4;
    view.limit   = limit;
    view.busy    = (busy != 3'd0);
  end

endmodule

// ===== rtl/tfe_front.sv =====
// Front end: parses format characters, tracks directive and room state,
// and turns each item into at most one job for the back end. Depends on tfe_pkg.
module tfe_front
  import tfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  in_item_t  item,
  input  cfg_view_t view,
  output logic      job_valid,
  output job_t      job
);

  logic        percent_pending, percent_pending_next;
  logic        verbatim_mode, verbatim_mode_next;
  logic        overflow_seen, overflow_seen_next;
  logic [15:0] written_count, written_count_next;

  logic [3:0][7:0] run_chars;
  logic [2:0]      run_n;
  logic [16:0]     run_end;
  logic            run_fits;
  logic [2:0]      end_need;
  logic [16:0]     end_total;
  logic            end_fits;

  function automatic logic [3:0][7:0] pair_chars(input bcd2_t v);
    logic [3:0][7:0] c;
    c    = '0;
    c[0] = digit_char(v[7:4]);
    c[1] = digit_char(v[3:0]);
    return c;
  endfunction

  // Characters an ordinary item wants to emit
  always_comb begin
    run_chars          = '0;
    run_n              = 3'd0;
    percent_pending_next = percent_pending;
    verbatim_mode_next = verbatim_mode;
    if (verbatim_mode) begin
      run_chars[0] = item.format_char;
      run_n        = 3'd1;
    end else if (!percent_pending) begin
      if (item.format_char == CH_PERCENT) begin
        percent_pending_next = 1'b1;
      end else begin
        run_chars[0] = item.format_char;
        run_n        = 3'd1;
      end
    end else begin
      percent_pending_next = 1'b0;
      run_n = 3'd2;
      case (item.format_char)
        CH_PERCENT: begin
          run_chars[0] = CH_PERCENT;
          run_n        = 3'd1;
        end
        CH_YEAR4: begin
          run_chars[0] = digit_char(view.year_hi[7:4]);
          run_chars[1] = digit_char(view.year_hi[3:0]);
          run_chars[2] = digit_char(view.year_lo[7:4]);
          run_chars[3] = digit_char(view.year_lo[3:0]);
          run_n        = 3'd4;
        end
        CH_YEAR2:  run_chars = pair_chars(view.year_lo);
        CH_MONTH:  run_chars = pair_chars(view.month);
        CH_DAY:    run_chars = pair_chars(view.day);
        CH_HOUR:   run_chars = pair_chars(view.hour);
        CH_MINUTE: run_chars = pair_chars(view.minute);
        CH_SECOND: run_chars = pair_chars(view.second);
        default: begin
          verbatim_mode_next = 1'b1;
          run_chars[0]       = CH_PERCENT;
          run_chars[1]       = item.format_char;
        end
      endcase
    end
  end

  assign run_end   = {1'b0, written_count} + {14'b0, run_n};
  assign run_fits  = !overflow_seen && (run_end <= {1'b0, view.limit});
  // A pending percent at the end must fit together with the NUL
  assign end_need  = percent_pending ? 3'd2 : 3'd1;
  assign end_total = {1'b0, written_count} + {14'b0, end_need};
  assign end_fits  = !overflow_seen && (end_total <= {1'b0, view.limit});

  always_comb begin
    job                = '0;
    job_valid          = 1'b0;
    overflow_seen_next = overflow_seen;
    written_count_next = written_count;
    if (item.end_marker) begin
      job_valid = accept;
      job.fin   = 1'b1;
      if (end_fits) begin
        job.chars[0] = percent_pending ? CH_PERCENT : CH_NUL;
        job.chars[1] = CH_NUL;
        job.count    = end_need;
        job.len      = end_total[15:0];
      end else begin
        job.chars[0] = CH_NUL;
        job.count    = 3'd1;
        job.ovf      = 1'b1;
      end
      overflow_seen_next = 1'b0;
      written_count_next = '0;
    end else if (run_n != 3'd0) begin
      if (run_fits) begin
        job_valid          = accept;
        job.chars          = run_chars;
        job.count          = run_n;
        written_count_next = run_end[15:0];
      end else begin
        overflow_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_pending <= 1'b0;
      verbatim_mode   <= 1'b0;
      overflow_seen   <= 1'b0;
      written_count   <= '0;
    end else if (accept) begin
      overflow_seen <= overflow_seen_next;
      written_count <= written_count_next;
      if (item.end_marker) begin
        percent_pending <= 1'b0;
        verbatim_mode   <= 1'b0;
      end else begin
        percent_pending <= percent_pending_next;
        verbatim_mode   <= verbatim_mode_next;
      end
    end
  end

endmodule

// ===== rtl/tfe_queue.sv =====
// Job queue between front and back end, a small circular buffer of job
// descriptors. Depends on tfe_pkg.
module tfe_queue
  import tfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output job_t head,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  a_no_write_full: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("queue written while full");
  a_no_read_empty: assert property (@(posedge clk) disable iff (rst) rd_en |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |=> count == $past(count) + 1'b1)
    else $error("queue occupancy out of step");

endmodule

// ===== rtl/tfe_back.sv =====
// Back end: walks the head job into the result register one character per
// cycle while the result register is empty or popped. Depends on tfe_pkg.
module tfe_back
  import tfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  output out_item_t result,
  output logic      empty,
  input  logic      pop
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load, take, last;

  assign load  = !out_valid || pop;
  assign take  = load && !q_empty;
  assign last  = (idx == 2'(head.count - 3'd1));
  assign q_pop = take && last;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (take) idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.out_char     <= head.chars[idx];
      result.last_of_run  <= last;
      result.finished     <= last && head.fin;
      result.overflow     <= last && head.ovf;
      result.total_length <= last ? head.len : 16'd0;
    end
  end

endmodule
